### rtl/mft_pkg.sv
package mft_pkg;

  localparam int SLOT_W          = 4;
  localparam int POS_W           = 12;
  localparam int Z_W             = 8;
  localparam int NIB_W           = 4;
  localparam int MAX_FINGERS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic       ACT_FINGER      = 1'b0;
  localparam logic       ACT_RELEASE_ALL = 1'b1;
  localparam logic [7:0] NIB_LO_MASK     = 8'h0F;
  localparam logic [7:0] NIB_HI_MASK     = 8'hF0;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot_id;
    logic [1:0]        presence_bits;
    logic [7:0]        x_high;
    logic [7:0]        y_high;
    logic [7:0]        xy_low;
    logic [7:0]        width_pair;
    logic [Z_W-1:0]    pressure;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] out_slot;
    logic              slot_reported;
    logic              touching;
    logic              coords_valid;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [Z_W-1:0]    out_pressure;
    logic [NIB_W-1:0]  width_major;
    logic [NIB_W-1:0]  width_minor;
    logic              any_pressed;
    logic              last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_FINGER      = 2'b01,
    CMD_RELEASE_ALL = 2'b10
  } cmd_kind_t;

  // classified record as it travels through the queue
  typedef struct packed {
    cmd_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    logic              present;
    logic              z_nz;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [Z_W-1:0]    pressure;
    logic [NIB_W-1:0]  w_major;
    logic [NIB_W-1:0]  w_minor;
    logic              frame_end;
  } cmd_t;

endpackage

### rtl/mft_front.sv
module mft_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  mft_pkg::in_item_t in_data,
  input  logic            q_full,
  output logic            q_push,
  output mft_pkg::cmd_t   q_cmd
);
  import mft_pkg::*;

  logic [NIB_W-1:0] w_hi;
  logic [NIB_W-1:0] w_lo;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign w_hi = NIB_W'((in_data.width_pair & NIB_HI_MASK) >> NIB_W);
  assign w_lo = NIB_W'(in_data.width_pair & NIB_LO_MASK);

  always_comb begin
    q_cmd           = '0;
    q_cmd.kind      = (in_data.action == ACT_RELEASE_ALL) ? CMD_RELEASE_ALL : CMD_FINGER;
    q_cmd.slot      = in_data.slot_id;
    q_cmd.present   = (in_data.presence_bits != 2'b00);
    q_cmd.z_nz      = (in_data.pressure != '0);
    q_cmd.pos_x     = {in_data.x_high, in_data.xy_low[3:0]};
    q_cmd.pos_y     = {in_data.y_high, in_data.xy_low[7:4]};
    q_cmd.pressure  = in_data.pressure;
    q_cmd.w_major   = (w_hi > w_lo) ? w_hi : w_lo;
    q_cmd.w_minor   = (w_hi > w_lo) ? w_lo : w_hi;
    q_cmd.frame_end = in_data.frame_end;
  end

endmodule

### rtl/mft_queue.sv
module mft_queue #(
  parameter int QUEUE_DEPTH = mft_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mft_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mft_pkg::cmd_t head_cmd
);
  import mft_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> !pop) else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

### rtl/mft_back.sv
module mft_back #(
  parameter int MAX_FINGERS = mft_pkg::MAX_FINGERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  mft_pkg::cmd_t     head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output mft_pkg::out_item_t out_data
);
  import mft_pkg::*;

  logic [MAX_FINGERS-1:0] slot_active_r, slot_active_nxt;
  logic                   acc_r, acc_nxt;
  logic [SLOT_W-1:0]      walk_cnt_r, walk_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic                   emit;
  logic                   is_rel;
  logic                   walk_last;
  logic [MAX_FINGERS-1:0] sel;
  logic                   in_range;
  logic                   act;
  logic                   new_act;
  logic                   pressed;
  out_item_t              res;

  assign is_rel    = (head_cmd.kind == CMD_RELEASE_ALL);
  assign walk_last = (walk_cnt_r == SLOT_W'(MAX_FINGERS - 1));
  assign emit      = head_valid && (!out_valid_r || out_ready);
  assign pop       = emit && (!is_rel || walk_last);

  always_comb begin
    for (int i = 0; i < MAX_FINGERS; i++) begin
      sel[i] = (head_cmd.slot == SLOT_W'(i));
    end
  end

  assign in_range = ({1'b0, head_cmd.slot} < (SLOT_W + 1)'(MAX_FINGERS));
  assign act      = |(slot_active_r & sel);
  // present record: activates on nonzero pressure; absent: releases
  assign new_act  = head_cmd.present ? (act || head_cmd.z_nz) : 1'b0;
  assign pressed  = in_range && head_cmd.present && new_act;

  always_comb begin
    res = '0;
    if (is_rel) begin
      res.out_slot      = walk_cnt_r;
      res.slot_reported = 1'b1;
      res.last          = walk_last;
    end else begin
      res.out_slot = head_cmd.slot;
      if (in_range) begin
        if (head_cmd.present) begin
          if (new_act) begin
            res.slot_reported = 1'b1;
            res.touching      = head_cmd.z_nz;
            res.coords_valid  = 1'b1;
            res.pos_x         = head_cmd.pos_x;
            res.pos_y         = head_cmd.pos_y;
            res.out_pressure  = head_cmd.pressure;
            res.width_major   = head_cmd.w_major;
            res.width_minor   = head_cmd.w_minor;
          end
        end else begin
          res.slot_reported = act;
        end
      end
      if (head_cmd.frame_end) begin
        res.any_pressed = acc_r || pressed;
        res.last        = 1'b1;
      end
    end
  end

  always_comb begin
    slot_active_nxt = slot_active_r;
    acc_nxt         = acc_r;
    walk_cnt_nxt    = walk_cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
      if (is_rel) begin
        if (walk_last) begin
          walk_cnt_nxt    = '0;
          slot_active_nxt = '0;
          acc_nxt         = 1'b0;
        end else begin
          walk_cnt_nxt = walk_cnt_r + 1'b1;
        end
      end else begin
        if (in_range) begin
          for (int i = 0; i < MAX_FINGERS; i++) begin
            if (sel[i]) begin
              slot_active_nxt[i] = new_act;
            end
          end
        end
        acc_nxt = head_cmd.frame_end ? 1'b0 : (acc_r || pressed);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_active_r <= '0;
      acc_r         <= 1'b0;
      walk_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      slot_active_r <= slot_active_nxt;
      acc_r         <= acc_nxt;
      walk_cnt_r    <= walk_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_walk_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit && is_rel && walk_last |=> (slot_active_r == '0) && !acc_r)
    else $error("release-all left state set");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, walk_cnt_r} < (SLOT_W + 1)'(MAX_FINGERS))
    else $error("walk counter past last slot");
  a_any_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.any_pressed |-> out_data_r.last)
    else $error("any_pressed off the last word");
  a_coords_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.coords_valid |-> out_data_r.slot_reported)
    else $error("coords on unreported slot");

endmodule

### rtl/multitouch_finger_tracker_top.sv
// Finger-slot tracker. Takes one finger-record word per cycle into a short queue (QUEUE_DEPTH
// words); in_ready drops only when that queue is full. Each finger record gives exactly one
// result word, registered once it reaches the head of the queue, so a steady stream runs at
// one word per cycle while out_ready is high. A release-all word walks all MAX_FINGERS slots
// with the back-end walk counter, one slot per cycle while out_ready is high; records behind
// it wait in the queue. Slot activity and the per-frame pressed flag are flops cleared at reset.
module multitouch_finger_tracker_top #(
  parameter int MAX_FINGERS = mft_pkg::MAX_FINGERS_DEF,
  parameter int QUEUE_DEPTH = mft_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mft_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mft_pkg::out_item_t out_data
);
  import mft_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  mft_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  mft_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  mft_back #(
    .MAX_FINGERS (MAX_FINGERS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
